@@ design/ipid_pkg.sv @@
// Package for the incremental PID position loop: widths, register indexes,
// reset values, controller states and the controller-to-datapath command.
// No dependencies; every other design file imports it.
package ipid_pkg;

  // Encoder counter width, the count width derived from it, and the other field widths
  localparam int COUNTER_BITS = 16;
  localparam int ENC_W        = 16;
  localparam int SETP_W       = 16;
  localparam int CNT_W        = COUNTER_BITS + 1;
  localparam int ERR_W        = 26;
  localparam int COEF_W       = 24;
  localparam int DPC_W        = 16;
  localparam int LIMIT_W      = 8;
  localparam int BAND_W       = 16;
  localparam int ACC_W        = 48;
  localparam int DUTY_W       = 8;
  localparam int DIR_W        = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  // Shared multiplier: signed A (count or error) by signed B (coef or scale)
  localparam int MUL_A_W = (CNT_W > ERR_W) ? CNT_W : ERR_W;
  localparam int MUL_B_W = COEF_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int POS_W   = PROD_W - 8;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SUM_W   = ERR_W + COEF_W + 2;
  localparam int NV_W    = ACC_W + 1;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 8'd170;

  // Register reset values
  localparam logic signed [COEF_W-1:0] COEF_NOW_RST   = 24'sd469246;
  localparam logic signed [COEF_W-1:0] COEF_PREV_RST  = -24'sd571465;
  localparam logic signed [COEF_W-1:0] COEF_PREV2_RST = 24'sd102236;
  localparam logic [DPC_W-1:0]         DPC_RST        = 16'd15320;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST      = 8'd50;
  localparam logic [BAND_W-1:0]        BAND_RST       = 16'd768;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_NOW    = 3'd0,
    CFG_COEF_PREV   = 3'd1,
    CFG_COEF_PREV2  = 3'd2,
    CFG_DEG_PER_CNT = 3'd3,
    CFG_DRIVE_LIMIT = 3'd4,
    CFG_SETTLE_BAND = 3'd5
  } cfg_idx_e;

  // Drive direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } drive_dir_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_ERR,
    S_M0,
    S_M1,
    S_M2,
    S_ACC,
    S_UPD
  } ctrl_state_e;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_POS,
    MUL_C0,
    MUL_C1,
    MUL_C2
  } mul_sel_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD
  } acc_op_e;

  // Command bundle from controller to datapath
  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     err_load;
    acc_op_e  acc_op;
    logic     upd;
  } ipid_cmd_t;

endpackage

@@ design/ipid_chan_if.sv @@
// Request and result channel interfaces of the PID position loop.
// Depends on ipid_pkg for the field widths.
interface ipid_in_if import ipid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ENC_W-1:0]         encoder_count;
  logic signed [SETP_W-1:0] setpoint_deg;
  logic                     run_enable;

  modport source (output valid, encoder_count, setpoint_deg, run_enable, input ready);
  modport sink   (input valid, encoder_count, setpoint_deg, run_enable, output ready);
endinterface

interface ipid_out_if import ipid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DUTY_W-1:0]       drive_duty;
  logic [DIR_W-1:0]        drive_dir;
  logic                    finished;
  logic signed [ERR_W-1:0] position_error;

  modport source (output valid, drive_duty, drive_dir, finished, position_error,
                  input ready);
  modport sink   (input valid, drive_duty, drive_dir, finished, position_error,
                  output ready);
endinterface

@@ design/ipid_ctrl.sv @@
// Sequencer of the PID position loop: steps one request through the shared
// multiplier and owns the result valid flag. Depends on ipid_pkg.
module ipid_ctrl import ipid_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ipid_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        can_load;

  // Result register free, or being emptied this cycle
  assign can_load = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_POS;
      S_POS:   state_d = S_ERR;
      S_ERR:   state_d = S_M0;
      S_M0:    state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_ACC;
      S_ACC:   state_d = S_UPD;
      S_UPD:   if (can_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_POS;
    cmd_o.acc_op  = ACC_HOLD;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_POS:   cmd_o.mul_sel = MUL_POS;
      S_ERR:   cmd_o.err_load = 1'b1;
      S_M0:    cmd_o.mul_sel = MUL_C0;
      S_M1: begin
        cmd_o.mul_sel = MUL_C1;
        cmd_o.acc_op  = ACC_INIT;
      end
      S_M2: begin
        cmd_o.mul_sel = MUL_C2;
        cmd_o.acc_op  = ACC_ADD;
      end
      S_ACC:   cmd_o.acc_op = ACC_ADD;
      S_UPD:   cmd_o.upd = can_load;
      default: cmd_o.load_in = 1'b0;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.upd) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/ipid_datapath.sv @@
// Datapath of the PID position loop: configuration registers, shared
// multiplier, error and accumulator registers, loop history and result
// register. Driven by the command from ipid_ctrl; depends on ipid_pkg.
module ipid_datapath import ipid_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ipid_cmd_t                cmd_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [ENC_W-1:0]         encoder_count_i,
  input  logic signed [SETP_W-1:0] setpoint_deg_i,
  input  logic                     run_enable_i,
  output logic [DUTY_W-1:0]        drive_duty_o,
  output logic [DIR_W-1:0]         drive_dir_o,
  output logic                     finished_o,
  output logic signed [ERR_W-1:0]  position_error_o
);

  // Configuration registers
  logic signed [COEF_W-1:0] coef_now_q, coef_prev_q, coef_prev2_q;
  logic [DPC_W-1:0]         dpc_q;
  logic [LIMIT_W-1:0]       limit_q;
  logic [BAND_W-1:0]        band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_now_q   <= COEF_NOW_RST;
      coef_prev_q  <= COEF_PREV_RST;
      coef_prev2_q <= COEF_PREV2_RST;
      dpc_q        <= DPC_RST;
      limit_q      <= LIMIT_RST;
      band_q       <= BAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COEF_NOW:    coef_now_q   <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_PREV:   coef_prev_q  <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_PREV2:  coef_prev2_q <= cfg_data_i[COEF_W-1:0];
        CFG_DEG_PER_CNT: dpc_q        <= cfg_data_i[DPC_W-1:0];
        CFG_DRIVE_LIMIT: limit_q      <= cfg_data_i[LIMIT_W-1:0];
        CFG_SETTLE_BAND: band_q       <= cfg_data_i[BAND_W-1:0];
        default:         ;
      endcase
    end
  end

  // Request registers
  logic [ENC_W-1:0]         enc_q;
  logic signed [SETP_W-1:0] setp_q;
  logic                     run_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      enc_q  <= encoder_count_i;
      setp_q <= setpoint_deg_i;
      run_q  <= run_enable_i;
    end
  end

  // Loop history
  logic signed [ERR_W-1:0] err_q, err_d;
  logic signed [ERR_W-1:0] e1_q, e2_q;
  logic signed [ACC_W-1:0] last_q;

  // Count read as a COUNTER_BITS two's complement value
  logic [COUNTER_BITS-1:0] enc_pad;
  logic signed [CNT_W-1:0] cnt_s;

  assign enc_pad = COUNTER_BITS'(enc_q);
  assign cnt_s   = $signed({enc_pad[COUNTER_BITS-1], enc_pad});

  // Shared multiplier, product registered
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_POS: begin
        mul_a = MUL_A_W'(cnt_s);
        mul_b = MUL_B_W'($signed({1'b0, dpc_q}));
      end
      MUL_C0: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = MUL_B_W'(coef_now_q);
      end
      MUL_C1: begin
        mul_a = MUL_A_W'(e1_q);
        mul_b = MUL_B_W'(coef_prev_q);
      end
      MUL_C2: begin
        mul_a = MUL_A_W'(e2_q);
        mul_b = MUL_B_W'(coef_prev2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Error: setpoint in Q.8 minus floored position, saturated to ERR_W
  logic signed [POS_W-1:0]    pos_s;
  logic signed [SETP_W+7:0]   setp_sh;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-ERR_W:0]      diff_top;

  always_comb begin
    pos_s    = prod_q[PROD_W-1:8];
    setp_sh  = $signed({setp_q, 8'h00});
    diff     = DIFF_W'(setp_sh) - DIFF_W'(pos_s);
    diff_top = diff[DIFF_W-1:ERR_W-1];
    if ((&diff_top) || !(|diff_top)) begin
      err_d = diff[ERR_W-1:0];
    end else begin
      err_d = $signed({diff[DIFF_W-1], {(ERR_W-1){~diff[DIFF_W-1]}}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_load) begin
      err_q <= err_d;
    end
  end

  // Product accumulator
  logic signed [SUM_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.acc_op)
      ACC_INIT: acc_q <= SUM_W'(prod_q);
      ACC_ADD:  acc_q <= acc_q + SUM_W'(prod_q);
      default:  acc_q <= acc_q;
    endcase
  end

  // New output, clamp and drive decode
  logic signed [SUM_W-1:0] acc_sh;
  logic signed [NV_W-1:0]  nv_wide;
  logic signed [ACC_W-1:0] nv;
  logic [LIMIT_W-1:0]      limit_eff;
  logic signed [ACC_W-1:0] lim_s;
  logic signed [ACC_W-1:0] cl;
  logic signed [16:0]      cl_small, cl_neg;
  logic [ERR_W-1:0]        mag_err;
  logic                    settled;
  logic [DUTY_W-1:0]       duty_d;
  logic [DIR_W-1:0]        dir_d;
  logic                    fin_d;

  always_comb begin
    acc_sh  = acc_q >>> 16;
    nv_wide = NV_W'(last_q) + NV_W'(acc_sh);
    if (nv_wide[NV_W-1] == nv_wide[NV_W-2]) begin
      nv = nv_wide[ACC_W-1:0];
    end else begin
      nv = $signed({nv_wide[NV_W-1], {(ACC_W-1){~nv_wide[NV_W-1]}}});
    end

    limit_eff = (limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
    lim_s     = ACC_W'($signed({1'b0, limit_eff, 8'h00}));
    if (nv > lim_s) begin
      cl = lim_s;
    end else if (nv < -lim_s) begin
      cl = -lim_s;
    end else begin
      cl = nv;
    end
    cl_small = cl[16:0];
    cl_neg   = -cl_small;

    mag_err = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
    settled = mag_err <= ERR_W'(band_q);

    duty_d = '0;
    dir_d  = DIR_STOP;
    fin_d  = 1'b1;
    if (run_q && !settled) begin
      fin_d = 1'b0;
      if (cl_small > 17'sd0) begin
        dir_d  = DIR_FWD;
        duty_d = cl_small[15:8];
      end else if (cl_small < 17'sd0) begin
        dir_d  = DIR_BWD;
        duty_d = cl_neg[15:8];
      end
    end
  end

  // History update, only while the loop runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q   <= '0;
      e2_q   <= '0;
      last_q <= '0;
    end else if (cmd_i.upd && run_q) begin
      e1_q   <= err_q;
      e2_q   <= e1_q;
      last_q <= nv;
    end
  end

  // Result register
  logic [DUTY_W-1:0]       duty_q;
  logic [DIR_W-1:0]        dir_q;
  logic                    fin_q;
  logic signed [ERR_W-1:0] perr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      duty_q <= duty_d;
      dir_q  <= dir_d;
      fin_q  <= fin_d;
      perr_q <= err_q;
    end
  end

  assign drive_duty_o     = duty_q;
  assign drive_dir_o      = dir_q;
  assign finished_o       = fin_q;
  assign position_error_o = perr_q;

endmodule

@@ design/incremental_pid_position_loop.sv @@
// Incremental PID position loop: one request in, one result out.
// A request is taken only once the previous one is through: it passes four
// times through one shared multiplier, then the accumulate and update steps,
// and the update waits until the result register can be loaded.
// Reset (async, active low) loads register defaults and clears the error
// history and last output; there is no clearing pass.
module incremental_pid_position_loop import ipid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ipid_in_if.sink               in_ch,
  ipid_out_if.source            out_ch
);

  ipid_cmd_t cmd;

  // Sequencer
  ipid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  ipid_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .encoder_count_i  (in_ch.encoder_count),
    .setpoint_deg_i   (in_ch.setpoint_deg),
    .run_enable_i     (in_ch.run_enable),
    .drive_duty_o     (out_ch.drive_duty),
    .drive_dir_o      (out_ch.drive_dir),
    .finished_o       (out_ch.finished),
    .position_error_o (out_ch.position_error)
  );

endmodule
